### design/tun_pkg.sv
`timescale 1ns / 1ps
package tun_pkg;
  localparam int IN_W    = 16;
  localparam int EDGE_W  = IN_W + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int V_W     = 24;
  localparam int LEN_W   = 6;
  localparam int SQ_W    = 2 * V_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int NORM_FRAC = 14;
  localparam int NUM_W   = V_W + NORM_FRAC + 2;
  localparam int DEN_W   = ROOT_W + 1;
  localparam int Q_W     = 17;
  localparam int OUT_W   = 16;

  typedef logic signed [CROSS_W-1:0] cross_t;

  // carried alongside the root and divide pipes
  typedef struct packed {
    logic                      degen;
    logic [2:0]                neg;
    logic [2:0][V_W-1:0]       v;
  } side_t;
endpackage

### design/tun_cross.sv
`timescale 1ns / 1ps
module tun_cross
  import tun_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [9*IN_W-1:0]       in_data,
  output logic                    out_valid,
  output cross_t [2:0]            cr
);
  logic signed [IN_W-1:0]   c [0:8];
  logic signed [EDGE_W-1:0] e1 [0:2];
  logic signed [EDGE_W-1:0] e2 [0:2];
  logic signed [PROD_W-1:0] p [0:5];
  logic [1:0] vld;

  always_comb begin
    for (int i = 0; i < 9; i++) c[i] = in_data[i*IN_W +: IN_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[0], in_valid};
      out_valid <= vld[1];
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= EDGE_W'(c[3+i]) - EDGE_W'(c[i]);
        e2[i] <= EDGE_W'(c[6+i]) - EDGE_W'(c[i]);
      end
      p[0] <= e1[1] * e2[2];
      p[1] <= e1[2] * e2[1];
      p[2] <= e1[2] * e2[0];
      p[3] <= e1[0] * e2[2];
      p[4] <= e1[0] * e2[1];
      p[5] <= e1[1] * e2[0];
      for (int i = 0; i < 3; i++)
        cr[i] <= CROSS_W'(p[2*i]) - CROSS_W'(p[2*i+1]);
    end
  end
endmodule

### design/tun_scale.sv
`timescale 1ns / 1ps
module tun_scale
  import tun_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  cross_t [2:0]         cr,
  output logic                 out_valid,
  output logic [SUM_W-1:0]     sum,
  output side_t                side
);
  localparam logic [LEN_W-1:0] TGT = LEN_W'(V_W);

  logic [CROSS_W-1:0] u_c [0:2];
  logic [CROSS_W-1:0] any_c;
  logic [LEN_W-1:0]   len_c;

  logic [CROSS_W-1:0] u [0:2];
  logic [LEN_W-1:0]   len;
  side_t              sa, sb, sc;
  logic [V_W-1:0]     v_c [0:2];
  logic [SQ_W-1:0]    sq [0:2];
  logic [2:0]         vld;

  always_comb begin
    any_c = '0;
    len_c = '0;
    for (int i = 0; i < 3; i++) begin
      u_c[i] = cr[i][CROSS_W-1] ? CROSS_W'(-cr[i]) : CROSS_W'(cr[i]);
      any_c = any_c | u_c[i];
    end
    // bit length of the OR equals that of the largest magnitude
    for (int i = 0; i < CROSS_W; i++)
      if (any_c[i]) len_c = LEN_W'(i + 1);
    for (int i = 0; i < 3; i++) begin
      if (len > TGT) v_c[i] = V_W'(u[i] >> (len - TGT));
      else           v_c[i] = V_W'(u[i] << (TGT - len));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
      out_valid <= vld[2];
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u[i] <= u_c[i];
        sa.neg[i] <= cr[i][CROSS_W-1];
        sa.v[i] <= '0;
      end
      sa.degen <= (any_c == '0);
      len <= len_c;
      sb.degen <= sa.degen;
      sb.neg <= sa.neg;
      for (int i = 0; i < 3; i++) begin
        sb.v[i] <= v_c[i];
        sq[i] <= sb.v[i] * sb.v[i];
      end
      sc <= sb;
      sum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
      side <= sc;
    end
  end
endmodule

### design/tun_isqrt.sv
`timescale 1ns / 1ps
module tun_isqrt
  import tun_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [SUM_W-1:0]      x_in,
  input  side_t                 side_in,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     root_out,
  output side_t                 side_out
);
  localparam int N    = ROOT_W;
  localparam int RW   = ROOT_W + 3;

  logic [SUM_W-1:0]  x    [0:N-1];
  logic [RW-1:0]     rem  [0:N-1];
  logic [ROOT_W-1:0] root [0:N-1];
  side_t             sd   [0:N-1];
  logic [N-1:0]      vld;

  logic [SUM_W-1:0]  x_n    [0:N-1];
  logic [RW-1:0]     rem_n  [0:N-1];
  logic [ROOT_W-1:0] root_n [0:N-1];

  logic [SUM_W-1:0]  xs;
  logic [RW-1:0]     rs, r2, trial;
  logic [ROOT_W-1:0] qs;

  // one root bit per stage: bring down two radicand bits, try 4q+1
  always_comb begin
    xs = '0; rs = '0; qs = '0; r2 = '0; trial = '0;
    for (int i = 0; i < N; i++) begin
      xs = (i == 0) ? x_in : x[(i == 0) ? 0 : i - 1];
      rs = (i == 0) ? '0   : rem[(i == 0) ? 0 : i - 1];
      qs = (i == 0) ? '0   : root[(i == 0) ? 0 : i - 1];
      r2 = {rs[RW-3:0], xs[SUM_W-1 -: 2]};
      trial = RW'({qs, 2'b01});
      x_n[i] = xs << 2;
      if (r2 >= trial) begin
        rem_n[i]  = r2 - trial;
        root_n[i] = {qs[ROOT_W-2:0], 1'b1};
      end else begin
        rem_n[i]  = r2;
        root_n[i] = {qs[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[N-2:0], in_valid};
    if (en) begin
      for (int i = 0; i < N; i++) begin
        x[i] <= x_n[i];
        rem[i] <= rem_n[i];
        root[i] <= root_n[i];
        sd[i] <= (i == 0) ? side_in : sd[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign out_valid = vld[N-1];
  assign root_out  = root[N-1];
  assign side_out  = sd[N-1];
endmodule

### design/tun_div.sv
`timescale 1ns / 1ps
module tun_div
  import tun_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [ROOT_W-1:0]     s,
  input  side_t                 side_in,
  output logic                  out_valid,
  output logic [2:0][Q_W-1:0]   q_out,
  output side_t                 side_out
);
  localparam int N  = Q_W;
  localparam int RW = DEN_W + 1;

  // prestage: num = v*2^15 + s, den = 2s
  logic [NUM_W-1:0] num0 [0:2];
  logic [DEN_W-1:0] den0;
  side_t            sd0;
  logic             vld0;

  logic [N-1:0]     nb  [0:N-1][0:2];
  logic [DEN_W-1:0] r   [0:N-1][0:2];
  logic [Q_W-1:0]   q   [0:N-1][0:2];
  logic [DEN_W-1:0] den [0:N-1];
  side_t            sd  [0:N-1];
  logic [N-1:0]     vld;

  logic [N-1:0]     nb_n [0:N-1][0:2];
  logic [DEN_W-1:0] r_n  [0:N-1][0:2];
  logic [Q_W-1:0]   q_n  [0:N-1][0:2];

  logic [N-1:0]     nbs;
  logic [DEN_W-1:0] rs, ds;
  logic [Q_W-1:0]   qs;
  logic [RW-1:0]    r2;

  always_comb begin
    nbs = '0; rs = '0; ds = '0; qs = '0; r2 = '0;
    for (int i = 0; i < N; i++) begin
      for (int l = 0; l < 3; l++) begin
        if (i == 0) begin
          nbs = num0[l][N-1:0];
          rs  = DEN_W'(num0[l][NUM_W-1:N]);
          qs  = '0;
          ds  = den0;
        end else begin
          nbs = nb[(i == 0) ? 0 : i - 1][l];
          rs  = r[(i == 0) ? 0 : i - 1][l];
          qs  = q[(i == 0) ? 0 : i - 1][l];
          ds  = den[(i == 0) ? 0 : i - 1];
        end
        r2 = {rs, nbs[N-1]};
        nb_n[i][l] = nbs << 1;
        if (r2 >= RW'(ds)) begin
          r_n[i][l] = DEN_W'(r2 - RW'(ds));
          q_n[i][l] = {qs[Q_W-2:0], 1'b1};
        end else begin
          r_n[i][l] = DEN_W'(r2);
          q_n[i][l] = {qs[Q_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
      vld <= '0;
    end else if (en) begin
      vld0 <= in_valid;
      vld <= {vld[N-2:0], vld0};
    end
    if (en) begin
      for (int l = 0; l < 3; l++)
        num0[l] <= NUM_W'({side_in.v[l], {(NORM_FRAC + 1){1'b0}}}) + NUM_W'(s);
      den0 <= {s, 1'b0};
      sd0 <= side_in;
      for (int i = 0; i < N; i++) begin
        for (int l = 0; l < 3; l++) begin
          nb[i][l] <= nb_n[i][l];
          r[i][l] <= r_n[i][l];
          q[i][l] <= q_n[i][l];
        end
        den[i] <= (i == 0) ? den0 : den[(i == 0) ? 0 : i - 1];
        sd[i] <= (i == 0) ? sd0 : sd[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign out_valid = vld[N-1];
  assign side_out  = sd[N-1];
  always_comb begin
    for (int l = 0; l < 3; l++) q_out[l] = q[N-1][l];
  end
endmodule

### design/triangle_unit_normal_unit.sv
`timescale 1ns / 1ps
// Unit face normal of a triangle. Each input beat carries three vertices in
// signed Q4.12; the output beat carries the normalized cross product
// (b-a) x (c-a) in signed Q2.14, with tuser set and the normal zeroed when
// the cross product is zero. Fully pipelined: one triangle per clock in and
// out unless m_tready stalls it; stages are cross product, scale and square,
// square root, divide and output register. All stages advance together and
// hold while a finished result waits on m_tready, so stalls drop nothing.
module triangle_unit_normal_unit
  import tun_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (16 bits each, lowest first)
  input  logic [143:0]  s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // normal_x, normal_y, normal_z (16 bits each, lowest first)
  output logic [47:0]   m_tdata,
  // degenerate
  output logic          m_tuser
);
  localparam logic [Q_W-1:0] ONE = Q_W'(1 << NORM_FRAC);

  logic en;
  logic cr_valid, sc_valid, rt_valid, dv_valid;
  cross_t [2:0] cr;
  logic [SUM_W-1:0] sum;
  side_t sc_side, rt_side, dv_side;
  logic [ROOT_W-1:0] root;
  logic [2:0][Q_W-1:0] q;
  logic [2:0][OUT_W-1:0] nrm;
  logic [Q_W-1:0] sat;

  // whole pipe moves when the output slot is free or being drained
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  tun_cross u_cross (
    .clk, .rst, .en,
    .in_valid (s_tvalid),
    .in_data  (s_tdata),
    .out_valid(cr_valid),
    .cr       (cr)
  );

  tun_scale u_scale (
    .clk, .rst, .en,
    .in_valid (cr_valid),
    .cr       (cr),
    .out_valid(sc_valid),
    .sum      (sum),
    .side     (sc_side)
  );

  tun_isqrt u_isqrt (
    .clk, .rst, .en,
    .in_valid (sc_valid),
    .x_in     (sum),
    .side_in  (sc_side),
    .out_valid(rt_valid),
    .root_out (root),
    .side_out (rt_side)
  );

  tun_div u_div (
    .clk, .rst, .en,
    .in_valid (rt_valid),
    .s        (root),
    .side_in  (rt_side),
    .out_valid(dv_valid),
    .q_out    (q),
    .side_out (dv_side)
  );

  // clamp to 1.0, apply sign, zero out a degenerate face
  always_comb begin
    sat = '0;
    for (int l = 0; l < 3; l++) begin
      sat = (q[l] > ONE) ? ONE : q[l];
      if (dv_side.degen)    nrm[l] = '0;
      else if (dv_side.neg[l]) nrm[l] = OUT_W'(-sat);
      else                  nrm[l] = OUT_W'(sat);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= dv_valid;
    if (en) begin
      m_tdata <= {nrm[2], nrm[1], nrm[0]};
      m_tuser <= dv_side.degen;
    end
  end
endmodule
